/* sv/utf8_decode_latin1_filter_assert.svh */
// Assertion macros for the UTF-8 decoder with Latin-1 filter.
// Used by the top level; needs signals named clk and arst_n in scope.
`ifndef UTF8_DECODE_LATIN1_FILTER_ASSERT_SVH
`define UTF8_DECODE_LATIN1_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property, quiet while reset is asserted.
`define U8L1_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked property that must hold even during reset.
`define U8L1_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U8L1_ASSERT(lbl, prop, msg)
`define U8L1_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* sv/u8l1_pkg.sv */
// Shared types, constants and decode functions for the UTF-8 decoder.
// No dependencies; used by u8l1_decode, u8l1_outq and the top level.
package u8l1_pkg;

	localparam int CP_W        = 21;
	localparam int MAX_RESULTS = 2;
	// Result queue depth; must be a power of two for pointer wrap.
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QLVL_W      = $clog2(QDEPTH + 1);

	localparam logic [7:0]      FALLBACK_RESET = 8'h3F;
	localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO        = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI        = 21'h00DFFF;
	localparam logic [CP_W-1:0] MIN_3BYTE      = 21'h000800;
	localparam logic [CP_W-1:0] MIN_4BYTE      = 21'h010000;
	localparam logic [7:0]      ASCII_LO       = 8'h20;
	localparam logic [7:0]      ASCII_HI       = 8'h7E;
	localparam logic [7:0]      LATIN_LO       = 8'hA0;
	localparam logic [7:0]      NEWLINE        = 8'h0A;

	// Continuation byte counts of the sequence kinds.
	localparam logic [1:0] EXTRA_2BYTE = 2'd1;
	localparam logic [1:0] EXTRA_3BYTE = 2'd2;
	localparam logic [1:0] EXTRA_4BYTE = 2'd3;

	// One result transaction.
	typedef struct packed {
		logic [7:0] cp;
		logic       sub;
		logic       last;
	} res_t;

	// Decoder sequence state, visible for checking.
	typedef struct packed {
		logic [1:0] pend;
		logic [1:0] extra;
	} dstat_t;

	// Result queue status.
	typedef struct packed {
		logic [QLVL_W-1:0] level;
		logic              room;
	} qstat_t;

	// Outcome of treating a byte as a lead byte.
	typedef struct packed {
		logic            emit;
		res_t            res;
		logic            opens;
		logic [CP_W-1:0] bits;
		logic [1:0]      extra;
	} lead_t;

	function automatic res_t fallback_res(input logic [7:0] fb);
		res_t r;
		r.cp   = fb;
		r.sub  = 1'b1;
		r.last = 1'b0;
		return r;
	endfunction

	// Newline, printable ASCII and the upper Latin-1 half pass through.
	function automatic res_t checked_res(input logic [CP_W-1:0] cp, input logic [7:0] fb);
		res_t r;
		logic kept;
		kept = (cp[CP_W-1:8] == '0) &&
			((cp[7:0] >= ASCII_LO && cp[7:0] <= ASCII_HI) ||
			 (cp[7:0] >= LATIN_LO) || (cp[7:0] == NEWLINE));
		if (kept) begin
			r.cp   = cp[7:0];
			r.sub  = 1'b0;
			r.last = 1'b0;
		end else begin
			r = fallback_res(fb);
		end
		return r;
	endfunction

	function automatic lead_t take_lead(input logic [7:0] b, input logic [7:0] fb);
		lead_t l;
		l.emit  = 1'b0;
		l.res   = fallback_res(fb);
		l.opens = 1'b0;
		l.bits  = '0;
		l.extra = 2'd0;
		if (b[7] == 1'b0) begin
			l.emit = 1'b1;
			l.res  = checked_res({13'd0, b}, fb);
		end else if (b[7:5] == 3'b110) begin
			// 0xC0 and 0xC1 could only give overlong two-byte forms.
			if (b[4:1] == 4'd0) begin
				l.emit = 1'b1;
			end else begin
				l.opens = 1'b1;
				l.bits  = {16'd0, b[4:0]};
				l.extra = EXTRA_2BYTE;
			end
		end else if (b[7:4] == 4'b1110) begin
			l.opens = 1'b1;
			l.bits  = {17'd0, b[3:0]};
			l.extra = EXTRA_3BYTE;
		end else if (b[7:3] == 5'b11110) begin
			l.opens = 1'b1;
			l.bits  = {18'd0, b[2:0]};
			l.extra = EXTRA_4BYTE;
		end else begin
			// Stray continuation byte or a lead of 0xF8 and above.
			l.emit = 1'b1;
		end
		return l;
	endfunction

	// Validate a completed sequence and filter its code point.
	function automatic res_t finish_res(input logic [CP_W-1:0] cp, input logic [1:0] extra,
		input logic [7:0] fb);
		logic bad;
		bad = (extra == EXTRA_3BYTE && cp < MIN_3BYTE) ||
			(extra == EXTRA_4BYTE && cp < MIN_4BYTE) ||
			(cp > CP_MAX) || (cp >= SURR_LO && cp <= SURR_HI);
		return bad ? fallback_res(fb) : checked_res(cp, fb);
	endfunction

endpackage

/* sv/u8l1_decode.sv */
// Sequence state and single-pass decode logic for one byte transaction.
// Depends on u8l1_pkg.
module u8l1_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic                kind,
	input  logic [7:0]          data_byte,
	input  logic [7:0]          fallback,
	output logic [1:0]          push_n,
	output u8l1_pkg::res_t      res0,
	output u8l1_pkg::res_t      res1,
	output u8l1_pkg::dstat_t    dstat
);
	import u8l1_pkg::*;

	logic [1:0]      pend_q, extra_q;
	logic [CP_W-1:0] acc_q;
	logic [1:0]      pend_d, extra_d;
	logic [CP_W-1:0] acc_d;
	logic [CP_W-1:0] acc_shift;
	lead_t           lead;

	assign acc_shift = {acc_q[CP_W-7:0], data_byte[5:0]};
	assign lead      = take_lead(data_byte, fallback);

	// Decode the held byte against the open sequence.
	always_comb begin
		push_n  = 2'd0;
		res0    = fallback_res(fallback);
		res1    = fallback_res(fallback);
		pend_d  = pend_q;
		extra_d = extra_q;
		acc_d   = acc_q;
		if (kind) begin
			// End of text flushes an open sequence.
			if (pend_q != 2'd0) begin
				push_n  = 2'd1;
				pend_d  = 2'd0;
				extra_d = 2'd0;
				acc_d   = '0;
			end
		end else if (pend_q != 2'd0) begin
			if (data_byte[7:6] == 2'b10) begin
				acc_d  = acc_shift;
				pend_d = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					push_n  = 2'd1;
					res0    = finish_res(acc_shift, extra_q, fallback);
					extra_d = 2'd0;
					acc_d   = '0;
				end
			end else begin
				// Broken sequence: fallback, then decode the byte as a lead.
				push_n  = 2'd1;
				pend_d  = 2'd0;
				extra_d = 2'd0;
				acc_d   = '0;
				if (lead.emit) begin
					push_n = 2'd2;
					res1   = lead.res;
				end
				if (lead.opens) begin
					pend_d  = lead.extra;
					extra_d = lead.extra;
					acc_d   = lead.bits;
				end
			end
		end else begin
			if (lead.emit) begin
				push_n = 2'd1;
				res0   = lead.res;
			end
			if (lead.opens) begin
				pend_d  = lead.extra;
				extra_d = lead.extra;
				acc_d   = lead.bits;
			end
		end
		// Mark the final result of this transaction.
		res0.last = (push_n == 2'd1);
		res1.last = (push_n == 2'd2);
	end

	// Sequence state advances only when the held byte is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 2'd0;
			extra_q <= 2'd0;
			acc_q   <= '0;
		end else if (fire) begin
			pend_q  <= pend_d;
			extra_q <= extra_d;
			acc_q   <= acc_d;
		end
	end

	assign dstat.pend  = pend_q;
	assign dstat.extra = extra_q;

endmodule

/* sv/u8l1_outq.sv */
// Small result queue: takes up to two results per cycle, gives one.
// Depends on u8l1_pkg.
module u8l1_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_n,
	input  u8l1_pkg::res_t   res0,
	input  u8l1_pkg::res_t   res1,
	input  logic             pop,
	output logic             out_valid,
	output u8l1_pkg::res_t   head,
	output u8l1_pkg::qstat_t qstat
);
	import u8l1_pkg::*;

	res_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QLVL_W-1:0] level_q;

	// Entries hold payload only and need no reset.
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			entry_q[wptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			entry_q[wptr_q + QPTR_W'(1)] <= res1;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			wptr_q  <= wptr_q + QPTR_W'(push_n);
			rptr_q  <= rptr_q + QPTR_W'(pop);
			level_q <= level_q + QLVL_W'(push_n) - QLVL_W'(pop);
		end
	end

	assign out_valid   = (level_q != '0);
	assign head        = entry_q[rptr_q];
	assign qstat.level = level_q;
	// Room is judged on the registered level so the stall paths stay apart.
	assign qstat.room  = (level_q <= QLVL_W'(QDEPTH - MAX_RESULTS));

endmodule

/* sv/utf8_decode_latin1_filter.sv */
// Top level of the UTF-8 decoder with Latin-1 filter.
// Depends on u8l1_pkg, u8l1_decode, u8l1_outq and the assertion header.
//
//   channel  signals                         direction
//   in       in_valid/in_stall, kind, data_byte    sink
//   out      out_valid/out_stall, code_point,
//            substituted, last                     source
//   cfg      cfg_we, cfg_wdata                     sink
//
// A byte is registered on acceptance in the input register, decoded from there
// once the queue has room, and its results are written into a four-entry result
// queue; the first result is valid at the output once it is in the queue.
// One byte per cycle is taken while the queue has room; a byte giving two results
// costs the queue an extra slot, so input stalls once it holds more than two results.
// Reset clears the sequence state, the queue and sets the fallback code to 0x3F.
`include "utf8_decode_latin1_filter_assert.svh"
module utf8_decode_latin1_filter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] code_point,
	output logic       substituted,
	output logic       last
);
	import u8l1_pkg::*;

	logic [7:0] fallback_code_q;
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;
	logic       fire_s1;
	logic [1:0] push_n;
	res_t       res0, res1, head;
	dstat_t     dstat;
	qstat_t     qstat;

	// Fallback code register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fallback_code_q <= FALLBACK_RESET;
		end else if (cfg_we) begin
			fallback_code_q <= cfg_wdata;
		end
	end

	// Input register stage.
	assign fire_s1  = valid_s1 && qstat.room;
	assign in_stall = valid_s1 && !qstat.room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			byte_s1 <= data_byte;
		end
	end

	u8l1_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire_s1),
		.kind      (kind_s1),
		.data_byte (byte_s1),
		.fallback  (fallback_code_q),
		.push_n    (push_n),
		.res0      (res0),
		.res1      (res1),
		.dstat     (dstat)
	);

	u8l1_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (fire_s1 ? push_n : 2'd0),
		.res0      (res0),
		.res1      (res1),
		.pop       (out_valid && !out_stall),
		.out_valid (out_valid),
		.head      (head),
		.qstat     (qstat)
	);

	assign code_point  = head.cp;
	assign substituted = head.sub;
	assign last        = head.last;

	// The queue never holds more results than it has entries.
	`U8L1_ASSERT(a_level_bound, qstat.level <= QLVL_W'(QDEPTH), "result queue overfilled")
	// A consumed byte always finds room for both of its results.
	`U8L1_ASSERT(a_push_fits, fire_s1 |-> (qstat.level <= QLVL_W'(QDEPTH - MAX_RESULTS)), "push without room")
	// Bytes still expected never exceed the length of the open sequence.
	`U8L1_ASSERT(a_seq_state, dstat.pend <= dstat.extra, "sequence counters disagree")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for utf8_decode_latin1_filter.
// Depends on u8l1_pkg for the result type; holds its own decoder model in a scoreboard class.

// Kind field of an input transaction.
localparam logic KIND_BYTE = 1'b0;
localparam logic KIND_END  = 1'b1;

// Models the decoder and keeps the results it still owes, oldest first.
class utf8_scoreboard;
	logic [7:0]         fallback;
	logic [1:0]         conts_left;
	logic [1:0]         conts_total;
	logic [20:0]        partial_cp;
	u8l1_pkg::res_t     owed_q[$];
	int                 errors;

	function new();
		fallback    = 8'h3F;
		conts_left  = 2'd0;
		conts_total = 2'd0;
		partial_cp  = 21'd0;
		errors      = 0;
	endfunction

	function void set_fallback(input logic [7:0] value);
		fallback = value;
	endfunction

	function int outstanding();
		return owed_q.size();
	endfunction

	function void emit(input logic [7:0] cp, input logic sub);
		u8l1_pkg::res_t r;
		r.cp   = cp;
		r.sub  = sub;
		r.last = 1'b0;
		owed_q = {owed_q, r};
	endfunction

	// Only newline, printable ASCII and the upper Latin-1 half pass the filter.
	function void emit_filtered(input logic [20:0] cp);
		if ((cp >= 21'h20 && cp <= 21'h7E) || (cp >= 21'hA0 && cp <= 21'hFF) || cp == 21'h0A)
			emit(cp[7:0], 1'b0);
		else
			emit(fallback, 1'b1);
	endfunction

	function void drop_sequence();
		conts_left  = 2'd0;
		conts_total = 2'd0;
		partial_cp  = 21'd0;
	endfunction

	function void open_sequence(input logic [20:0] bits, input logic [1:0] conts);
		partial_cp  = bits;
		conts_total = conts;
		conts_left  = conts;
	endfunction

	// Treat a byte as the start of a new sequence.
	function void decode_lead(input logic [7:0] b);
		if (b < 8'h80) begin
			emit_filtered({13'd0, b});
		end else if ((b & 8'hE0) == 8'hC0) begin
			// The two lowest two-byte leads can only spell overlong forms.
			if (b < 8'hC2)
				emit(fallback, 1'b1);
			else
				open_sequence({16'd0, b[4:0]}, 2'd1);
		end else if ((b & 8'hF0) == 8'hE0) begin
			open_sequence({17'd0, b[3:0]}, 2'd2);
		end else if ((b & 8'hF8) == 8'hF0) begin
			open_sequence({18'd0, b[2:0]}, 2'd3);
		end else begin
			emit(fallback, 1'b1);
		end
	endfunction

	// Validate a completed sequence before filtering it.
	function void complete_sequence();
		logic [20:0] cp;
		logic [1:0]  conts;
		cp    = partial_cp;
		conts = conts_total;
		drop_sequence();
		if ((conts == 2'd2 && cp < 21'h800) || (conts == 2'd3 && cp < 21'h10000) ||
			cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF))
			emit(fallback, 1'b1);
		else
			emit_filtered(cp);
	endfunction

	// Called for every accepted input transaction.
	function void note_input(input logic k, input logic [7:0] b);
		int prior_size;
		prior_size = owed_q.size();
		if (k == KIND_END) begin
			if (conts_left != 2'd0) begin
				emit(fallback, 1'b1);
				drop_sequence();
			end
		end else if (conts_left != 2'd0) begin
			if (b[7:6] == 2'b10) begin
				partial_cp = {partial_cp[14:0], b[5:0]};
				conts_left = conts_left - 2'd1;
				if (conts_left == 2'd0)
					complete_sequence();
			end else begin
				// A lead inside a sequence aborts it and is then decoded afresh.
				emit(fallback, 1'b1);
				drop_sequence();
				decode_lead(b);
			end
		end else begin
			decode_lead(b);
		end
		if (owed_q.size() > prior_size)
			owed_q[owed_q.size() - 1].last = 1'b1;
	endfunction

	task report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		errors++;
	endtask

	// Called for every accepted result transaction.
	task check_result(input logic [7:0] cp, input logic sub, input logic is_last);
		u8l1_pkg::res_t want;
		if (owed_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result code_point=%02h", cp));
		end else begin
			want = owed_q.pop_front();
			if (cp !== want.cp)
				report_mismatch($sformatf("code_point %02h, expected %02h", cp, want.cp));
			if (sub !== want.sub)
				report_mismatch($sformatf("substituted %b, expected %b", sub, want.sub));
			if (is_last !== want.last)
				report_mismatch($sformatf("last %b, expected %b", is_last, want.last));
		end
	endtask
endclass

module testbench;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 415;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic       kind      = KIND_BYTE;
	logic [7:0] data_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] code_point;
	logic       substituted;
	logic       last;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int sent_items    = 0;

	utf8_scoreboard sb = new();

	utf8_decode_latin1_filter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.substituted(substituted),
		.last       (last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Receiver side: random stall, changed only at the falling edge.
	initial begin
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Check every result transaction taken at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(code_point, substituted, last);
	end

	// Send one input transaction; entered and left just after a falling edge.
	task send_item(input logic k, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		data_byte <= b;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		sb.note_input(k, b);
		sent_items++;
		@(negedge clk);
	endtask

	// Send up to four data bytes, most significant byte first.
	task send_bytes(input int count, input logic [31:0] bytes);
		logic [31:0] rest;
		rest = bytes;
		repeat (count) begin
			send_item(KIND_BYTE, rest[31:24]);
			rest = rest << 8;
		end
	endtask

	function automatic logic [7:0] any_cont();
		return 8'h80 | 8'($urandom_range(63));
	endfunction

	// Hold the input off until every owed result has come out.
	task drain_results();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task write_fallback(input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_fallback(value);
	endtask

	// Edge values and each special case of the decoder.
	task run_directed();
		send_bytes(4, 32'h000A7E7F);    // NUL and DEL are filtered, newline and tilde pass
		send_bytes(3, 32'h80C0C100);    // stray continuation and overlong two-byte leads
		send_bytes(2, 32'hC3BF0000);    // top of the Latin-1 range
		send_bytes(2, 32'hC2800000);    // C1 control range is filtered
		send_bytes(3, 32'hE0808000);    // overlong three-byte form
		send_bytes(3, 32'hEDA08000);    // surrogate
		send_bytes(4, 32'hF4908080);    // above the Unicode range
		send_bytes(4, 32'hF08FBFBF);    // overlong four-byte form
		send_bytes(2, 32'hF8FF0000);    // leads that can never start a sequence
		send_bytes(2, 32'hC3410000);    // aborted sequence, then a plain letter
		send_bytes(4, 32'hE282C3A9);    // aborted sequence whose breaker opens a new one
		send_item(KIND_BYTE, 8'hC3);
		send_item(KIND_END, 8'hFF);     // end of text flushes the open sequence
		send_item(KIND_END, 8'h00);     // end of text with nothing open
	endtask

	// One random unit: mostly well-formed sequences, some broken ones and noise.
	task send_random_unit();
		int         sel;
		int         need;
		logic [7:0] lead;
		logic [7:0] breaker;
		sel = $urandom_range(99);
		if (sel < 30) begin
			send_item(KIND_BYTE, 8'($urandom_range(127)));
		end else if (sel < 50) begin
			// At least half of the two-byte forms land in the Latin-1 range.
			if ($urandom_range(1))
				lead = 8'hC2 + 8'($urandom_range(1));
			else
				lead = 8'($urandom_range(8'hC2, 8'hDF));
			send_item(KIND_BYTE, lead);
			send_item(KIND_BYTE, any_cont());
		end else if (sel < 62) begin
			// E0 tends to overlong forms and ED to surrogates.
			case ($urandom_range(3))
				0: lead = 8'hE0;
				1: lead = 8'hED;
				default: lead = 8'($urandom_range(8'hE0, 8'hEF));
			endcase
			send_item(KIND_BYTE, lead);
			send_item(KIND_BYTE, any_cont());
			send_item(KIND_BYTE, any_cont());
		end else if (sel < 72) begin
			send_item(KIND_BYTE, 8'($urandom_range(8'hF0, 8'hF7)));
			repeat (3) send_item(KIND_BYTE, any_cont());
		end else if (sel < 84) begin
			// Truncated sequence, ended by a non-continuation byte or end of text.
			lead = 8'($urandom_range(8'hC2, 8'hF4));
			need = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
			send_item(KIND_BYTE, lead);
			repeat ($urandom_range(need - 1)) send_item(KIND_BYTE, any_cont());
			if ($urandom_range(1)) begin
				send_item(KIND_END, 8'($urandom_range(255)));
			end else begin
				breaker = 8'($urandom_range(255));
				if (breaker[7:6] == 2'b10)
					breaker[6] = 1'b1;
				send_item(KIND_BYTE, breaker);
			end
		end else if (sel < 92) begin
			send_item(KIND_END, 8'($urandom_range(255)));
		end else begin
			send_item(KIND_BYTE, 8'($urandom_range(255)));
		end
	endtask

	task run_random_phase(input int send_pct, input int recv_pct, input bit hold_midway);
		int start;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start = sent_items;
		while (sent_items - start < PHASE_ITEMS) begin
			send_random_unit();
			if (hold_midway && sent_items - start >= PHASE_ITEMS / 2) begin
				drain_results();
				hold_midway = 1'b0;
			end
		end
	endtask

	// Main sequence: reset, directed checks, then three random phases.
	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		drain_results();
		write_fallback(8'hFF);
		run_random_phase(31, 60, 1'b1);
		drain_results();
		write_fallback(8'h00);
		run_random_phase(60, 31, 1'b0);
		drain_results();
		write_fallback(8'($urandom_range(1, 254)));
		run_random_phase(0, 0, 1'b0);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#1000000;
		$display("testbench: FAIL");
		$finish;
	end
endmodule

/* utf8_decode_latin1_filter.f */
+incdir+sv
sv/u8l1_pkg.sv
sv/u8l1_decode.sv
sv/u8l1_outq.sv
sv/utf8_decode_latin1_filter.sv
tb/testbench.sv
